/* rtl/phc_pkg.sv */
// phc_pkg: shared types and constants of the polygon half-space clipper
// no dependencies; imported by phc_mul, phc_div and polygon_halfspace_clipper

package phc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_FLOOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOAT_MARGIN  = 3'd5;

    // register widths and reset values
    localparam int NORMAL_W = 16;
    localparam int OFFSET_W = 32;
    localparam int LIMIT_W  = 16;

    localparam logic signed [NORMAL_W-1:0] NORMAL_X_RST = 16'sd16384;
    localparam logic [LIMIT_W-1:0]         FLOOR_RST    = 16'd7;
    localparam logic [LIMIT_W-1:0]         MARGIN_RST   = 16'd7;

    // fraction bits of the plane normal
    localparam int NORMAL_FRAC = 14;

    // request kinds on s_tuser
    localparam logic REQ_PRIME  = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_MUL,
        ST_DOT,
        ST_DIST,
        ST_DECIDE,
        ST_DIV,
        ST_LERP,
        ST_EMIT_CROSS,
        ST_EMIT_VERT,
        ST_EMIT_END,
        ST_UPDATE
    } phc_state_t;

endpackage

/* rtl/phc_mul.sv */
// phc_mul: shared signed multiplier with a registered product
// uses phc_pkg; serves the dot products and the crossing interpolation

module phc_mul #(
    parameter int A_W = 18,
    parameter int B_W = 33
) (
    input  logic                   clk,
    input  logic signed [A_W-1:0]  a,
    input  logic signed [B_W-1:0]  b,
    output logic signed [A_W+B_W-1:0] prod
);
    import phc_pkg::*;

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

    assign prod = prod_reg;

endmodule

/* rtl/phc_div.sv */
// phc_div: radix-2 restoring divider for the crossing parameter
// uses phc_pkg; gives min(num/den, 1) with FRAC_W fraction bits, den nonzero

module phc_div #(
    parameter int NUM_W  = 33,
    parameter int FRAC_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num_mag,
    input  logic [NUM_W-1:0]  den_mag,
    output logic              done,
    output logic [FRAC_W:0]   quot
);
    import phc_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);
    localparam logic [FRAC_W:0] ONE = {1'b1, {FRAC_W{1'b0}}};

    logic               busy_reg;
    logic               first_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W:0]     rem_reg;
    logic [NUM_W-1:0]   den_reg;
    logic [FRAC_W:0]    quot_reg;

    logic [NUM_W:0]     rem_sh;
    logic [NUM_W:0]     den_ext;
    logic               sh_ge;
    logic               init_ge;

    assign den_ext = {1'b0, den_reg};
    assign rem_sh  = {rem_reg[NUM_W-1:0], 1'b0};
    assign sh_ge   = (rem_sh >= den_ext);
    // quotient of one or more clamps at once
    assign init_ge = (rem_reg >= den_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= CNT_W'(FRAC_W);
            end
            else if (busy_reg)
            begin
                if (first_reg)
                begin
                    first_reg <= 1'b0;
                    if (init_ge)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num_mag};
            den_reg  <= den_mag;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                if (init_ge)
                begin
                    quot_reg <= ONE;
                end
            end
            else
            begin
                rem_reg  <= sh_ge ? (rem_sh - den_ext) : rem_sh;
                quot_reg <= {quot_reg[FRAC_W-1:0], sh_ge};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/polygon_halfspace_clipper.sv */
// polygon_halfspace_clipper: one plane step of a convex polygon clip, Q16.16 fixed point
// uses phc_pkg, phc_mul (shared multiplier) and phc_div (serial divider)
//
// A face is fed as a prime request holding its closing vertex (s_tuser 0), then its
// vertices (s_tuser 1) with s_tlast on the final one. Each vertex request gives up to
// two result requests: the interpolated plane crossing (m_tuser[0] set) and the vertex
// itself; a final vertex that gives nothing yields one end marker with m_tuser[1] clear.
// m_tlast marks the last result of the face, m_tuser[2] the last result of a request.
// The block takes one request at a time; s_tready is high only while it waits for one.
// Cost per request is set by the sequencer around one shared multiplier. A vertex with a
// crossing also runs the divide step, which ends early when the crossing parameter clamps
// at one and is skipped when it clamps at zero; any stall of the output register adds to
// the cost. Configuration is to be written by the user only while idle; the block itself
// does not enforce this.

module polygon_halfspace_clipper #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,

    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // in_x, in_y, in_z, zero padding
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
    // req_type
    input  logic                                         s_tuser,
    // face_last
    input  logic                                         s_tlast,

    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // out_x, out_y, out_z, zero padding
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]           m_tdata,
    // is_crossing, point_valid, run_last
    output logic [2:0]                                   m_tuser,
    // face_end
    output logic                                         m_tlast,

    input  logic                                         cfg_we,
    input  logic [phc_pkg::CFG_IDX_W-1:0]                cfg_addr,
    input  logic [phc_pkg::CFG_DATA_W-1:0]               cfg_wdata
);
    import phc_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int FB     = FRACTION_BITS;
    localparam int DATA_W = ((3*CW+7)/8)*8;
    localparam int MA     = (FB + 2 > NORMAL_W) ? FB + 2 : NORMAL_W;
    localparam int BW     = CW + 1;
    localparam int PW     = MA + BW;
    localparam int AW     = PW + 2;
    localparam int DW     = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;
    localparam int KW     = ((CW > LIMIT_W + 1) ? CW : LIMIT_W + 1) + 1;

    localparam logic [2:0] DOT_CNT_END  = 3'd3;
    localparam logic [2:0] LERP_CNT_END = 3'd4;

    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [AW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[CW-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // configuration
    logic signed [NORMAL_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [OFFSET_W-1:0] off_reg;
    logic [LIMIT_W-1:0]         floor_reg, margin_reg;

    // sequencer
    phc_state_t state_reg, state_next;
    logic [2:0] cnt_reg;

    // previous vertex
    logic signed [CW-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [CW-1:0] prev_dot_reg, prev_dist_reg;

    // current request
    logic signed [CW-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic                 is_vertex_reg, last_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [CW-1:0] dot_reg, dist_reg;
    logic signed [DW-1:0] num_reg;
    logic signed [CW:0]   divr_reg;
    logic                 keep_reg;
    logic [FB:0]          t_reg;
    logic signed [BW-1:0] diff_reg;
    logic signed [CW-1:0] crx_reg, cry_reg, crz_reg;

    // output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [2:0]        out_user_reg;
    logic              out_last_reg;

    // combinational
    logic signed [MA-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;
    logic                 div_start, div_done;
    logic [FB:0]          div_quot;
    logic [CW:0]          div_mag;
    logic [DW-1:0]        num_mag;
    logic signed [KW-1:0] keep_sum;
    logic                 sign_change, cross_now, keep_now, same_sign;
    logic signed [CW-1:0] lerp_base;
    logic signed [CW-1:0] lerp_val;
    logic                 out_free, out_load;

    phc_mul #(.A_W(MA), .B_W(BW)) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    phc_div #(.NUM_W(DW), .FRAC_W(FB)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (num_mag),
        .den_mag (DW'(div_mag)),
        .done    (div_done),
        .quot    (div_quot)
    );

    // multiplier operands: normal times coordinate, or t times coordinate difference
    always_comb
    begin
        if (state_reg == ST_LERP)
        begin
            mul_a = MA'($signed({1'b0, t_reg}));
            mul_b = diff_reg;
        end
        else
        begin
            case (cnt_reg)
                3'd0:
                begin
                    mul_a = MA'(nx_reg);
                    mul_b = BW'(cur_x_reg);
                end
                3'd1:
                begin
                    mul_a = MA'(ny_reg);
                    mul_b = BW'(cur_y_reg);
                end
                default:
                begin
                    mul_a = MA'(nz_reg);
                    mul_b = BW'(cur_z_reg);
                end
            endcase
        end
    end

    // crossing and keep decisions
    assign div_mag   = divr_reg[CW] ? $unsigned(-divr_reg) : $unsigned(divr_reg);
    assign num_mag   = num_reg[DW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
    assign keep_sum  = KW'(dist_reg) + $signed(KW'(margin_reg));
    assign keep_now  = !keep_sum[KW-1] && (keep_sum != '0);
    assign sign_change =
        (dist_reg[CW-1] && !prev_dist_reg[CW-1] && (prev_dist_reg != '0)) ||
        (!dist_reg[CW-1] && (dist_reg != '0) && prev_dist_reg[CW-1]);
    assign cross_now = sign_change && (div_mag > (CW+1)'(floor_reg));
    // numerator and divider of opposite sign clamp t to zero
    assign same_sign = (num_reg[DW-1] == divr_reg[CW]) || (num_reg == '0);

    always_comb
    begin
        case (cnt_reg)
            3'd2:    lerp_base = cur_x_reg;
            3'd3:    lerp_base = cur_y_reg;
            default: lerp_base = cur_z_reg;
        endcase
    end

    assign lerp_val = sat_cw(AW'(lerp_base) + AW'(mul_prod >>> FB));

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DOT_MUL;
            end
            ST_DOT_MUL:
            begin
                if (cnt_reg == DOT_CNT_END)
                    state_next = ST_DOT;
            end
            ST_DOT:
            begin
                state_next = ST_DIST;
            end
            ST_DIST:
            begin
                state_next = is_vertex_reg ? ST_DECIDE : ST_UPDATE;
            end
            ST_DECIDE:
            begin
                if (cross_now)
                begin
                    if (same_sign)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_LERP;
                    end
                end
                else if (keep_now)
                    state_next = ST_EMIT_VERT;
                else if (last_reg)
                    state_next = ST_EMIT_END;
                else
                    state_next = ST_UPDATE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_LERP;
            end
            ST_LERP:
            begin
                if (cnt_reg == LERP_CNT_END)
                    state_next = ST_EMIT_CROSS;
            end
            ST_EMIT_CROSS:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = keep_reg ? ST_EMIT_VERT : ST_UPDATE;
                end
            end
            ST_EMIT_VERT, ST_EMIT_END:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            nx_reg        <= NORMAL_X_RST;
            ny_reg        <= '0;
            nz_reg        <= '0;
            off_reg       <= '0;
            floor_reg     <= FLOOR_RST;
            margin_reg    <= MARGIN_RST;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            prev_dot_reg  <= '0;
            prev_dist_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next == state_reg) ? cnt_reg + 1'b1 : '0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_NORMAL_X:      nx_reg     <= cfg_wdata[NORMAL_W-1:0];
                    REG_NORMAL_Y:      ny_reg     <= cfg_wdata[NORMAL_W-1:0];
                    REG_NORMAL_Z:      nz_reg     <= cfg_wdata[NORMAL_W-1:0];
                    REG_PLANE_OFFSET:  off_reg    <= cfg_wdata[OFFSET_W-1:0];
                    REG_DIVIDER_FLOOR: floor_reg  <= cfg_wdata[LIMIT_W-1:0];
                    REG_BLOAT_MARGIN:  margin_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_UPDATE)
            begin
                prev_x_reg    <= cur_x_reg;
                prev_y_reg    <= cur_y_reg;
                prev_z_reg    <= cur_z_reg;
                prev_dot_reg  <= dot_reg;
                prev_dist_reg <= dist_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_x_reg     <= s_tdata[CW-1:0];
                    cur_y_reg     <= s_tdata[2*CW-1:CW];
                    cur_z_reg     <= s_tdata[3*CW-1:2*CW];
                    is_vertex_reg <= (s_tuser == REQ_VERTEX);
                    last_reg      <= s_tlast;
                    acc_reg       <= '0;
                end
            end
            ST_DOT_MUL:
            begin
                // product of the previous cycle lands here
                if (cnt_reg != '0)
                    acc_reg <= acc_reg + AW'(mul_prod);
            end
            ST_DOT:
            begin
                dot_reg <= sat_cw(acc_reg >>> NORMAL_FRAC);
            end
            ST_DIST:
            begin
                dist_reg <= sat_cw(AW'(dot_reg) - AW'(off_reg));
                num_reg  <= DW'(off_reg) - DW'(dot_reg);
                divr_reg <= (CW+1)'(prev_dot_reg) - (CW+1)'(dot_reg);
            end
            ST_DECIDE:
            begin
                keep_reg  <= keep_now;
                t_reg     <= '0;
            end
            ST_DIV:
            begin
                if (div_done)
                    t_reg <= div_quot;
            end
            ST_LERP:
            begin
                // difference, product and sum run one axis apart
                case (cnt_reg)
                    3'd0: diff_reg <= BW'(prev_x_reg) - BW'(cur_x_reg);
                    3'd1: diff_reg <= BW'(prev_y_reg) - BW'(cur_y_reg);
                    3'd2:
                    begin
                        diff_reg <= BW'(prev_z_reg) - BW'(cur_z_reg);
                        crx_reg  <= lerp_val;
                    end
                    3'd3: cry_reg <= lerp_val;
                    3'd4: crz_reg <= lerp_val;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            unique case (state_reg)
                ST_EMIT_CROSS:
                begin
                    out_data_reg <= DATA_W'({crz_reg, cry_reg, crx_reg});
                    out_user_reg <= {!keep_reg, 1'b1, 1'b1};
                    out_last_reg <= last_reg && !keep_reg;
                end
                ST_EMIT_VERT:
                begin
                    out_data_reg <= DATA_W'({cur_z_reg, cur_y_reg, cur_x_reg});
                    out_user_reg <= {1'b1, 1'b1, 1'b0};
                    out_last_reg <= last_reg;
                end
                default:
                begin
                    // end marker of a face whose final vertex gave nothing
                    out_data_reg <= '0;
                    out_user_reg <= {1'b1, 1'b0, 1'b0};
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LERP) |-> (t_reg <= ONE))
        else $error("crossing parameter above one");

    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tlast && m_tuser[2]))
        else $error("end marker without face end and run last");

endmodule
